FILE: hdl/aspr_pkg.sv
// Shared types and constants for the audio packet sequence router.
// Holds the packet/result payload structs, action and type codes, and the
// command/status bundles between the controller and the datapath. No dependencies.
package aspr_pkg;

    localparam int unsigned SPEAKER_FIFO_BYTES_DEF = 8192;
    localparam int unsigned MAX_PACKET_BYTES_DEF   = 512;

    localparam int unsigned HDR_BYTES   = 4;
    localparam int unsigned SILENCE_MAX = 8191;

    // quotient width of the silence divider follows the free-space field
    localparam int unsigned SPACE_W   = 14;
    localparam int unsigned DIV_STEPS = SPACE_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [7:0] TYPE_SPEAKER  = 8'd0;
    localparam logic [7:0] TYPE_MIC      = 8'd1;
    localparam logic [7:0] TYPE_FEEDBACK = 8'd2;
    localparam logic [7:0] TYPE_COMMAND  = 8'd3;

    localparam logic [1:0] MODE_STANDBY      = 2'd0;
    localparam logic [1:0] MODE_DONGLE_AUDIO = 2'd1;
    localparam logic [1:0] MODE_DONGLE_TONE  = 2'd2;
    localparam logic [1:0] MODE_HEADSET      = 2'd3;

    localparam logic [2:0] ADDR_DEVICE_MODE = 3'd0;

    typedef enum logic [3:0] {
        ACT_SHORT      = 4'd0,
        ACT_LATE       = 4'd1,
        ACT_FULL       = 4'd2,
        ACT_SPK_WRITE  = 4'd3,
        ACT_MIC        = 4'd4,
        ACT_FB_USB     = 4'd5,
        ACT_FB_TONE    = 4'd6,
        ACT_COMMAND    = 4'd7,
        ACT_WRONG_MODE = 4'd8,
        ACT_UNKNOWN    = 4'd9
    } action_t;

    typedef struct packed {
        logic [7:0]         packet_type;
        logic [15:0]        sequence_number;
        logic [8:0]         packet_length;
        logic [31:0]        first_payload_word;
        logic [SPACE_W-1:0] speaker_space;
    } pkt_t;

    typedef struct packed {
        logic [3:0]  action_code;
        logic [8:0]  payload_bytes;
        logic [12:0] silence_payloads;
        logic [14:0] lost_count;
        logic [31:0] feedback_out;
    } res_t;

    typedef struct packed {
        logic ready;     // controller can take a request
        logic load;      // capture incoming request
        logic decide;    // classify, update sequence state, seed divider
        logic div_step;  // one restoring division step
        logic emit;      // move result into the output register
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic out_free;
    } sts_t;

endpackage

FILE: hdl/audio_packet_sequence_router_unit.sv
// Audio packet sequence router, top level: APB register, controller and
// datapath. Depends on aspr_pkg, aspr_ctrl and aspr_dp.
//
// Usage:
//  - pkt channel (pkt_valid/pkt_ready/pkt) takes one received packet header
//    request; res channel (res_valid/res_ready/res) returns one routing
//    result per request, in order.
//  - APB register 0 (byte address 0) holds device_mode; write it only while
//    no request is in flight.
//  - A request is decoded the cycle after it is taken. Speaker writes after
//    a sequence gap run a restoring divider for the silence count, one
//    quotient bit per cycle.
//  - One request is in flight at a time: pkt_ready is high only while the
//    controller is idle.
//  - The output register holds a finished result while the next request is
//    taken; if res_ready stays low the following result waits in the
//    controller and pkt_ready stays low until the register frees.
//  - Reset clears device_mode to 0, the expected sequence to 0 and the sync
//    flag; the first speaker packet in headset mode sets the sequence.
module audio_packet_sequence_router_unit
    import aspr_pkg::*;
#(
    parameter int unsigned SPEAKER_FIFO_BYTES = SPEAKER_FIFO_BYTES_DEF,
    parameter int unsigned MAX_PACKET_BYTES   = MAX_PACKET_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        pkt_valid,
    output logic        pkt_ready,
    input  pkt_t        pkt,

    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    logic [1:0] device_mode_reg;
    logic       cfg_wr;
    cmd_t       cmd;
    sts_t       sts;

    // register index is paddr[2]; low address bits are byte lanes
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == ADDR_DEVICE_MODE[2]);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_DEVICE_MODE[2]) ? {30'd0, device_mode_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            device_mode_reg <= MODE_STANDBY;
        else if (cfg_wr)
            device_mode_reg <= pwdata[1:0];
    end

    aspr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    aspr_dp #(
        .SPEAKER_FIFO_BYTES (SPEAKER_FIFO_BYTES),
        .MAX_PACKET_BYTES   (MAX_PACKET_BYTES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .device_mode (device_mode_reg),
        .pkt         (pkt),
        .res_ready   (res_ready),
        .sts         (sts),
        .res_valid   (res_valid),
        .res         (res)
    );

    assign pkt_ready = cmd.ready;

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_ready |=> !pkt_ready)
        else $error("request taken while another is in flight");

    a_silence_cap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.silence_payloads <= res.lost_count[12:0]
                      || res.lost_count > 15'd8191)
        else $error("silence count exceeds loss count");

    a_silence_only_write: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.action_code != ACT_SPK_WRITE |-> res.silence_payloads == 13'd0)
        else $error("silence reported outside speaker write");

    a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && !paddr[2] |=> device_mode_reg == $past(pwdata[1:0]))
        else $error("device mode write lost");

endmodule

FILE: hdl/aspr_ctrl.sv
// Controller FSM for the audio packet sequence router.
// Sequences capture, classification, the silence divider and result hand-off.
// Depends on aspr_pkg.
module aspr_ctrl
    import aspr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pkt_valid,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (pkt_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                cnt_next   = '0;
                state_next = sts.need_div ? S_DIV : S_EMIT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: hdl/aspr_dp.sv
// Datapath for the audio packet sequence router: request capture, routing
// decode, sequence tracking, restoring silence divider and output register.
// Depends on aspr_pkg; driven by aspr_ctrl commands.
module aspr_dp
    import aspr_pkg::*;
#(
    parameter int unsigned SPEAKER_FIFO_BYTES = SPEAKER_FIFO_BYTES_DEF,
    parameter int unsigned MAX_PACKET_BYTES   = MAX_PACKET_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic [1:0] device_mode,
    input  pkt_t       pkt,
    input  logic       res_ready,
    output sts_t       sts,
    output logic       res_valid,
    output res_t       res
);

    pkt_t               pkt_reg;
    logic [15:0]        expected_reg;
    logic               synced_reg;

    action_t            code_reg;
    logic [8:0]         pl_reg;
    logic [14:0]        lost_reg;
    logic [31:0]        fb_reg;
    logic               div_used_reg;
    logic [8:0]         rem_reg;
    logic [SPACE_W-1:0] dq_reg;

    res_t               res_reg;
    logic               res_valid_reg;

    // decode of the captured request
    logic [8:0]         len_c;
    logic [SPACE_W-1:0] space_c;
    logic [8:0]         pl;
    logic [15:0]        exp_eff;
    logic [15:0]        delta;
    logic               full;
    action_t            code;
    logic               need_div;

    always_comb
    begin
        len_c   = (32'(pkt_reg.packet_length) > 32'(MAX_PACKET_BYTES))
                  ? 9'(MAX_PACKET_BYTES) : pkt_reg.packet_length;
        space_c = (32'(pkt_reg.speaker_space) > 32'(SPEAKER_FIFO_BYTES))
                  ? SPACE_W'(SPEAKER_FIFO_BYTES) : pkt_reg.speaker_space;
        pl      = len_c - 9'(HDR_BYTES);
        exp_eff = synced_reg ? expected_reg : pkt_reg.sequence_number;
        delta   = pkt_reg.sequence_number - exp_eff;
        full    = space_c < SPACE_W'(pl);

        if (len_c < 9'(HDR_BYTES))
        begin
            code = ACT_SHORT;
        end
        else
        begin
            case (pkt_reg.packet_type)
                TYPE_SPEAKER:
                begin
                    if (device_mode != MODE_HEADSET)
                        code = ACT_WRONG_MODE;
                    else if (delta[15])
                        code = ACT_LATE;
                    else if (full)
                        code = ACT_FULL;
                    else
                        code = ACT_SPK_WRITE;
                end
                TYPE_MIC:
                begin
                    code = (device_mode inside {MODE_DONGLE_AUDIO, MODE_DONGLE_TONE})
                           ? ACT_MIC : ACT_WRONG_MODE;
                end
                TYPE_FEEDBACK:
                begin
                    if (device_mode == MODE_DONGLE_AUDIO)
                        code = ACT_FB_USB;
                    else if (device_mode == MODE_DONGLE_TONE)
                        code = ACT_FB_TONE;
                    else
                        code = ACT_WRONG_MODE;
                end
                TYPE_COMMAND:
                begin
                    code = ACT_COMMAND;
                end
                default:
                begin
                    code = ACT_UNKNOWN;
                end
            endcase
        end

        // zero payload means no silence, and no division by zero
        need_div = (code == ACT_SPK_WRITE) && (delta != 16'd0) && (pl != 9'd0);
    end

    // restoring divider step: (space - pl) / pl, one quotient bit per cycle
    logic [9:0] trial;
    logic       ge;
    always_comb
    begin
        trial = {rem_reg, dq_reg[SPACE_W-1]};
        ge    = trial >= {1'b0, pl_reg};
    end

    // silence count capped by the loss count and by the field range
    logic [14:0] cap1;
    logic [12:0] silence;
    always_comb
    begin
        cap1    = (15'(dq_reg) > lost_reg) ? lost_reg : 15'(dq_reg);
        silence = (cap1 > 15'(SILENCE_MAX)) ? 13'(SILENCE_MAX) : cap1[12:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pkt_reg <= pkt;
        end
        if (cmd.decide)
        begin
            code_reg     <= code;
            pl_reg       <= pl;
            div_used_reg <= need_div;
            lost_reg     <= (code == ACT_FULL || code == ACT_SPK_WRITE) ? delta[14:0] : '0;
            fb_reg       <= (code == ACT_FB_USB || code == ACT_FB_TONE)
                            ? pkt_reg.first_payload_word : '0;
            rem_reg      <= '0;
            dq_reg       <= space_c - SPACE_W'(pl);
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? 9'(trial - {1'b0, pl_reg}) : trial[8:0];
            dq_reg  <= {dq_reg[SPACE_W-2:0], ge};
        end
        if (cmd.emit)
        begin
            res_reg.action_code      <= code_reg;
            res_reg.payload_bytes    <= (code_reg == ACT_SPK_WRITE || code_reg == ACT_MIC)
                                        ? pl_reg : '0;
            res_reg.silence_payloads <= div_used_reg ? silence : '0;
            res_reg.lost_count       <= lost_reg;
            res_reg.feedback_out     <= fb_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg  <= '0;
            synced_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.decide && (code == ACT_FULL || code == ACT_SPK_WRITE))
            begin
                expected_reg <= pkt_reg.sequence_number + 16'd1;
                synced_reg   <= 1'b1;
            end
            if (cmd.emit)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    assign sts.need_div = need_div;
    assign sts.out_free = !res_valid_reg || res_ready;
    assign res_valid    = res_valid_reg;
    assign res          = res_reg;

endmodule

FILE: tb/tb_audio_packet_sequence_router_unit.sv
// Self-checking testbench for audio_packet_sequence_router_unit.
// Drives packet header requests and APB mode writes, predicts each routing result
// in-line, and compares them in order. Depends on aspr_pkg and the RTL top.
module tb_audio_packet_sequence_router_unit
    import aspr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SETTLE_CYCLES = 20;  // covers the divider path

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        pkt_valid = 1'b0;
    logic        pkt_ready;
    pkt_t        pkt_bus = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    res_t        res_bus;

    // predictor state
    logic [1:0]  dev_mode = MODE_STANDBY;
    logic [15:0] next_seq = '0;
    logic        seq_locked = 1'b0;

    pkt_t        packets_to_send[$];
    res_t        routes_due[$];
    logic [15:0] stream_seq;
    bit          quiet = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    audio_packet_sequence_router_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt_bus),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res_bus)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Routing decision for one accepted request; updates the sequence tracker.
    function automatic res_t route_packet(pkt_t p);
        res_t        r;
        int unsigned len;
        int unsigned pl;
        int unsigned space;
        int unsigned ins;
        logic [15:0] delta;
        r = '0;
        len = 32'(p.packet_length);
        if (len > MAX_PACKET_BYTES_DEF)
            len = MAX_PACKET_BYTES_DEF;
        if (len < HDR_BYTES)
        begin
            r.action_code = ACT_SHORT;
            return r;
        end
        pl = len - HDR_BYTES;
        case (p.packet_type)
            TYPE_SPEAKER:
            begin
                if (dev_mode != MODE_HEADSET)
                    r.action_code = ACT_WRONG_MODE;
                else
                begin
                    if (!seq_locked)
                    begin
                        next_seq = p.sequence_number;
                        seq_locked = 1'b1;
                    end
                    delta = p.sequence_number - next_seq;
                    if (delta[15])
                        r.action_code = ACT_LATE;
                    else
                    begin
                        r.lost_count = delta[14:0];
                        space = 32'(p.speaker_space);
                        if (space > SPEAKER_FIFO_BYTES_DEF)
                            space = SPEAKER_FIFO_BYTES_DEF;
                        next_seq = p.sequence_number + 16'd1;
                        if (space < pl)
                            r.action_code = ACT_FULL;
                        else
                        begin
                            ins = 0;
                            if (delta != 0 && pl != 0)
                            begin
                                ins = (space - pl) / pl;
                                if (ins > 32'(delta))
                                    ins = 32'(delta);
                                if (ins > SILENCE_MAX)
                                    ins = SILENCE_MAX;
                            end
                            r.action_code = ACT_SPK_WRITE;
                            r.payload_bytes = pl[8:0];
                            r.silence_payloads = ins[12:0];
                        end
                    end
                end
            end
            TYPE_MIC:
            begin
                if (dev_mode == MODE_DONGLE_AUDIO || dev_mode == MODE_DONGLE_TONE)
                begin
                    r.action_code = ACT_MIC;
                    r.payload_bytes = pl[8:0];
                end
                else
                    r.action_code = ACT_WRONG_MODE;
            end
            TYPE_FEEDBACK:
            begin
                if (dev_mode == MODE_DONGLE_AUDIO)
                begin
                    r.action_code = ACT_FB_USB;
                    r.feedback_out = p.first_payload_word;
                end
                else if (dev_mode == MODE_DONGLE_TONE)
                begin
                    r.action_code = ACT_FB_TONE;
                    r.feedback_out = p.first_payload_word;
                end
                else
                    r.action_code = ACT_WRONG_MODE;
            end
            TYPE_COMMAND:
                r.action_code = ACT_COMMAND;
            default:
                r.action_code = ACT_UNKNOWN;
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic pkt_t make_packet(logic [7:0] kind, logic [15:0] seq, logic [8:0] len,
                                         logic [31:0] word, logic [13:0] space);
        pkt_t p;
        p.packet_type = kind;
        p.sequence_number = seq;
        p.packet_length = len;
        p.first_payload_word = word;
        p.speaker_space = space;
        return p;
    endfunction

    // Request driver: valid holds until accepted, random idle bursts between requests.
    always @(posedge clk)
    begin
        if (!rst_n)
            pkt_valid <= 1'b0;
        else
        begin
            if (pkt_valid && pkt_ready)
                routes_due.push_back(route_packet(pkt_bus));
            if (!pkt_valid || pkt_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    pkt_valid <= 1'b0;
                end
                else if (packets_to_send.size() > 0)
                begin
                    pkt_bus <= packets_to_send.pop_front();
                    pkt_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 4) == 0)
                        gap_left = $urandom_range(1, 3);
                end
                else
                    pkt_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random backpressure.
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (res_valid && res_ready)
            begin
                if (routes_due.size() == 0)
                begin
                    $error("result with none pending: 0x%0h", res_bus);
                    mismatches++;
                end
                else
                begin
                    res_t want;
                    want = routes_due.pop_front();
                    check_field("action_code", 32'(want.action_code),
                                32'(res_bus.action_code));
                    check_field("payload_bytes", 32'(want.payload_bytes),
                                32'(res_bus.payload_bytes));
                    check_field("silence_payloads", 32'(want.silence_payloads),
                                32'(res_bus.silence_payloads));
                    check_field("lost_count", 32'(want.lost_count),
                                32'(res_bus.lost_count));
                    check_field("feedback_out", want.feedback_out, res_bus.feedback_out);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 3);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL audio_packet_sequence_router_unit");
            $finish;
        end
    end

    // Wait until every request is accepted and every result is back, then drain.
    task automatic settle();
        while (packets_to_send.size() != 0 || pkt_valid || routes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(logic [1:0] m);
        logic [31:0] junk;
        junk = $urandom();
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_DEVICE_MODE;
        pwdata <= {junk[31:2], m};  // upper bits are don't-care
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        dev_mode = m;
    endtask

    task automatic queue_random(int unsigned n);
        pkt_t        p;
        int unsigned pick;
        int unsigned len;
        int unsigned pl;
        for (int unsigned i = 0; i < n; i++)
        begin
            p.first_payload_word = $urandom();
            pick = $urandom_range(0, 19);
            if (pick == 0)
                len = $urandom_range(0, 3);
            else if (pick == 1)
                len = $urandom_range(500, 511);
            else if (pick == 2)
                len = HDR_BYTES;
            else if (pick < 6)
                len = $urandom_range(5, 40);
            else
                len = $urandom_range(4, 511);
            p.packet_length = len[8:0];
            pl = (len >= HDR_BYTES) ? len - HDR_BYTES : 0;

            pick = $urandom_range(0, 9);
            if (pick == 0)
                p.speaker_space = 14'($urandom_range(0, 16383));
            else if (pick < 3)
                p.speaker_space = 14'($urandom_range(0, pl));
            else
                p.speaker_space = 14'($urandom_range(pl, SPEAKER_FIFO_BYTES_DEF));

            if (dev_mode == MODE_HEADSET && $urandom_range(0, 9) < 7)
            begin
                p.packet_type = TYPE_SPEAKER;
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    p.sequence_number = stream_seq;
                else if (pick < 75)
                    p.sequence_number = stream_seq + 16'($urandom_range(1, 20));
                else if (pick < 80)
                    p.sequence_number = stream_seq + 16'($urandom_range(21, 32767));
                else if (pick < 92)
                    p.sequence_number = stream_seq - 16'($urandom_range(1, 32768));
                else
                    p.sequence_number = 16'($urandom_range(0, 65535));
                // late packets leave the stream position alone
                if (pick < 80 || pick >= 92)
                    stream_seq = p.sequence_number + 16'd1;
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    p.packet_type = TYPE_MIC;
                else if (pick < 6)
                    p.packet_type = TYPE_FEEDBACK;
                else if (pick < 8)
                    p.packet_type = TYPE_COMMAND;
                else if (pick == 8)
                    p.packet_type = TYPE_SPEAKER;
                else
                    p.packet_type = 8'($urandom_range(4, 255));
                p.sequence_number = 16'($urandom_range(0, 65535));
            end
            packets_to_send.push_back(p);
        end
    endtask

    initial
    begin
        logic [1:0] mode_plan[10];
        mode_plan = '{MODE_HEADSET, MODE_DONGLE_AUDIO, MODE_HEADSET, MODE_DONGLE_TONE,
                      MODE_STANDBY, MODE_HEADSET, MODE_DONGLE_AUDIO, MODE_HEADSET,
                      MODE_DONGLE_TONE, MODE_HEADSET};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // standby after reset: speaker, mic and feedback misrouted; commands pass; unknown and short flagged
        packets_to_send.push_back(make_packet(TYPE_SPEAKER, 16'h1234, 9'd100, 32'h0, 14'd8192));
        packets_to_send.push_back(make_packet(TYPE_MIC, 16'h0, 9'd511, 32'h0, 14'd0));
        packets_to_send.push_back(make_packet(TYPE_FEEDBACK, 16'h0, 9'd8, 32'h1, 14'd0));
        packets_to_send.push_back(make_packet(TYPE_COMMAND, 16'hFFFF, 9'd4, 32'h0, 14'd0));
        packets_to_send.push_back(make_packet(8'hFF, 16'h0, 9'd20, 32'h0, 14'd0));
        packets_to_send.push_back(make_packet(TYPE_SPEAKER, 16'h0, 9'd0, 32'h0, 14'd0));
        packets_to_send.push_back(make_packet(8'hFF, 16'h0, 9'd3, 32'h0, 14'd0));
        settle();

        set_mode(MODE_HEADSET);
        // sync on first packet, excess free space clamps
        packets_to_send.push_back(make_packet(TYPE_SPEAKER, 16'hFFFE, 9'd511, 32'h0, 14'h3FFF));
        // empty payload, no room at all still fits
        packets_to_send.push_back(make_packet(TYPE_SPEAKER, 16'hFFFF, 9'd4, 32'h0, 14'd0));
        // gap across wrap, silence capped by lost count
        packets_to_send.push_back(make_packet(TYPE_SPEAKER, 16'h0004, 9'd14, 32'h0, 14'd100));
        packets_to_send.push_back(make_packet(TYPE_SPEAKER, 16'h0003, 9'd14, 32'h0, 14'd100));
        // gap with empty payload inserts nothing
        packets_to_send.push_back(make_packet(TYPE_SPEAKER, 16'h0009, 9'd4, 32'h0, 14'd8192));
        // FIFO full still advances the sequence
        packets_to_send.push_back(make_packet(TYPE_SPEAKER, 16'h0010, 9'd104, 32'h0, 14'd50));
        // largest forward distance, silence saturates
        packets_to_send.push_back(make_packet(TYPE_SPEAKER, 16'h8010, 9'd5, 32'h0, 14'd8192));
        // distance of exactly half the range counts as late
        packets_to_send.push_back(make_packet(TYPE_SPEAKER, 16'h0011, 9'd5, 32'h0, 14'd8192));
        // silence limited by free space rather than loss
        packets_to_send.push_back(make_packet(TYPE_SPEAKER, 16'h801B, 9'd24, 32'h0, 14'd100));
        packets_to_send.push_back(make_packet(TYPE_MIC, 16'h0, 9'd50, 32'h0, 14'd0));
        packets_to_send.push_back(make_packet(TYPE_FEEDBACK, 16'h0, 9'd8, 32'h5, 14'd0));
        settle();

        set_mode(MODE_DONGLE_AUDIO);
        // feedback word passes even with a short payload
        packets_to_send.push_back(make_packet(TYPE_FEEDBACK, 16'h0, 9'd4, 32'hFFFF_FFFF, 14'd0));
        packets_to_send.push_back(make_packet(TYPE_MIC, 16'h0, 9'd511, 32'h0, 14'd0));
        packets_to_send.push_back(make_packet(TYPE_SPEAKER, 16'h801C, 9'd40, 32'h0, 14'd8192));
        settle();

        set_mode(MODE_DONGLE_TONE);
        packets_to_send.push_back(make_packet(TYPE_FEEDBACK, 16'h0, 9'd8, 32'h0, 14'd0));
        packets_to_send.push_back(make_packet(TYPE_FEEDBACK, 16'h0, 9'd6, 32'hA5A5_5A5A, 14'd0));
        packets_to_send.push_back(make_packet(TYPE_MIC, 16'h0, 9'd4, 32'h0, 14'd0));
        packets_to_send.push_back(make_packet(TYPE_COMMAND, 16'h0, 9'd9, 32'h0, 14'd0));
        settle();

        stream_seq = 16'h801C;
        foreach (mode_plan[i])
        begin
            set_mode(mode_plan[i]);
            if (i == $size(mode_plan) - 1)
                quiet = 1'b1;  // final stretch runs without idling
            queue_random(55);
            settle();
        end

        if (mismatches == 0 && routes_due.size() == 0)
            $display("PASS audio_packet_sequence_router_unit");
        else
            $display("FAIL audio_packet_sequence_router_unit");
        $finish;
    end

endmodule
